// File: rtl/core/ckvsp_pkg.sv
// Package for the checked key/value sentence parser core.
// Character codes, parse phase and status codes, hex digit decode.
// No dependencies.
`default_nettype none

package ckvsp_pkg;

  localparam int MAX_SENTENCE = 255;
  localparam int LEN_W        = 8;

  // parse phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_GAP   = 3'd1;
  localparam logic [2:0] PH_TOKEN = 3'd2;
  localparam logic [2:0] PH_HEX   = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  // result status codes
  localparam logic [1:0] ST_UPDATED   = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_ABSENT    = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_A  = 8'h61;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - CH_ZERO;
      r.ok = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - CH_UC_A + 8'd10;
      r.ok = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - CH_LC_A + 8'd10;
      r.ok = 1'b1;
    end
    r.nibble = d[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/checked_key_value_sentence_parser_core.sv
// Checked key/value sentence parser core, top level.
// A result is loaded into the output register when its CR/LF byte is accepted.
// Throughput: one byte per cycle; the parse state updates in a single pass per byte.
// Input stalls only while a result sits unread in the output register.
// Reset (rst, synchronous, active high): idle phase, match_key 0, stored reading 0.
// Depends on ckvsp_pkg.
`default_nettype none

module checked_key_value_sentence_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: match_key
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // byte stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      reading,
  output logic [7:0]       received_checksum,
  output logic [7:0]       computed_checksum
);

  // parse state
  logic [7:0]                   match_key;
  logic [2:0]                   phase, phase_next;
  logic [7:0]                   running_xor, running_xor_next;
  logic [7:0]                   hex_accum, hex_accum_next;
  logic [1:0]                   hex_digits_seen, hex_digits_seen_next;
  logic                         in_value_token, in_value_token_next;
  logic [7:0]                   key_accum, key_accum_next;
  logic [15:0]                  value_accum, value_accum_next;
  logic                         past_decimal_point, past_decimal_point_next;
  logic [15:0]                  pending_value, pending_value_next;
  logic                         pending_found, pending_found_next;
  logic [15:0]                  stored_reading, stored_reading_next;
  logic [ckvsp_pkg::LEN_W-1:0]  sentence_length, sentence_length_next;

  // result produced by this byte
  logic        emit;
  logic [1:0]  emit_status;

  logic        accept;
  logic        is_term;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [19:0] value_x10;
  logic [7:0]  key_x10;
  ckvsp_pkg::hex_digit_t hex_d;

  assign cfg_ready = 1'b1;
  // output register frees a slot when empty or being drained this cycle
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  assign is_term   = (rx_byte == ckvsp_pkg::CH_CR) || (rx_byte == ckvsp_pkg::CH_LF);
  assign is_digit  = rx_byte inside {[8'h30:8'h39]};
  assign digit_val = 4'(rx_byte - ckvsp_pkg::CH_ZERO);
  assign hex_d     = ckvsp_pkg::hex_decode(rx_byte);
  // x10 as shift-and-add
  assign key_x10   = (key_accum << 3) + (key_accum << 1) + {4'd0, digit_val};
  assign value_x10 = ({4'd0, value_accum} << 3) + ({4'd0, value_accum} << 1)
                     + {16'd0, digit_val};

  always_comb begin
    phase_next              = phase;
    running_xor_next        = running_xor;
    hex_accum_next          = hex_accum;
    hex_digits_seen_next    = hex_digits_seen;
    in_value_token_next     = in_value_token;
    key_accum_next          = key_accum;
    value_accum_next        = value_accum;
    past_decimal_point_next = past_decimal_point;
    pending_value_next      = pending_value;
    pending_found_next      = pending_found;
    stored_reading_next     = stored_reading;
    sentence_length_next    = sentence_length;
    emit                    = 1'b0;
    emit_status             = ckvsp_pkg::ST_MALFORMED;

    if (accept) begin
      if (is_term) begin
        if (phase != ckvsp_pkg::PH_IDLE) begin
          emit = 1'b1;
          if (phase != ckvsp_pkg::PH_HEX || hex_digits_seen != 2'd2) begin
            emit_status = ckvsp_pkg::ST_MALFORMED;
          end else if (hex_accum != running_xor) begin
            emit_status = ckvsp_pkg::ST_MISMATCH;
          end else if (pending_found) begin
            emit_status         = ckvsp_pkg::ST_UPDATED;
            stored_reading_next = pending_value;
          end else begin
            emit_status = ckvsp_pkg::ST_ABSENT;
          end
          // back to idle for the next sentence
          phase_next              = ckvsp_pkg::PH_IDLE;
          running_xor_next        = '0;
          hex_accum_next          = '0;
          hex_digits_seen_next    = '0;
          in_value_token_next     = 1'b0;
          key_accum_next          = '0;
          value_accum_next        = '0;
          past_decimal_point_next = 1'b0;
          pending_value_next      = '0;
          pending_found_next      = 1'b0;
          sentence_length_next    = '0;
        end
      end else if (phase == ckvsp_pkg::PH_IDLE) begin
        // start byte, skipped
        phase_next           = ckvsp_pkg::PH_GAP;
        sentence_length_next = ckvsp_pkg::LEN_W'(1);
      end else if (phase == ckvsp_pkg::PH_DRAIN) begin
        // drop until terminator
      end else if (sentence_length >= ckvsp_pkg::LEN_W'(ckvsp_pkg::MAX_SENTENCE)) begin
        phase_next = ckvsp_pkg::PH_DRAIN;
      end else begin
        sentence_length_next = sentence_length + ckvsp_pkg::LEN_W'(1);
        if (phase == ckvsp_pkg::PH_HEX) begin
          if (!hex_d.ok || hex_digits_seen == 2'd2) begin
            phase_next = ckvsp_pkg::PH_DRAIN;
          end else begin
            hex_accum_next       = {hex_accum[3:0], hex_d.nibble};
            hex_digits_seen_next = hex_digits_seen + 2'd1;
          end
        end else if (rx_byte == ckvsp_pkg::CH_STAR ||
                     rx_byte == ckvsp_pkg::CH_COMMA ||
                     rx_byte == ckvsp_pkg::CH_COLON) begin
          if (rx_byte != ckvsp_pkg::CH_STAR) begin
            running_xor_next = running_xor ^ rx_byte;
          end
          // close an open token
          if (phase == ckvsp_pkg::PH_TOKEN) begin
            if (!in_value_token) begin
              in_value_token_next = 1'b1;
            end else begin
              if (key_accum == match_key) begin
                pending_value_next = value_accum;
                pending_found_next = 1'b1;
              end
              in_value_token_next = 1'b0;
            end
            key_accum_next          = '0;
            value_accum_next        = '0;
            past_decimal_point_next = 1'b0;
            phase_next              = ckvsp_pkg::PH_GAP;
          end
          if (rx_byte == ckvsp_pkg::CH_STAR) begin
            phase_next           = ckvsp_pkg::PH_HEX;
            hex_accum_next       = '0;
            hex_digits_seen_next = '0;
          end
        end else begin
          // token character
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = ckvsp_pkg::PH_TOKEN;
          if (!past_decimal_point) begin
            if (!is_digit) begin
              past_decimal_point_next = 1'b1;
            end else if (!in_value_token) begin
              key_accum_next = key_x10;
            end else begin
              value_accum_next = (value_x10 > 20'd65535) ? 16'hFFFF : value_x10[15:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_key          <= '0;
      phase              <= ckvsp_pkg::PH_IDLE;
      running_xor        <= '0;
      hex_accum          <= '0;
      hex_digits_seen    <= '0;
      in_value_token     <= 1'b0;
      key_accum          <= '0;
      value_accum        <= '0;
      past_decimal_point <= 1'b0;
      pending_value      <= '0;
      pending_found      <= 1'b0;
      stored_reading     <= '0;
      sentence_length    <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        match_key <= cfg_data;
      end
      phase              <= phase_next;
      running_xor        <= running_xor_next;
      hex_accum          <= hex_accum_next;
      hex_digits_seen    <= hex_digits_seen_next;
      in_value_token     <= in_value_token_next;
      key_accum          <= key_accum_next;
      value_accum        <= value_accum_next;
      past_decimal_point <= past_decimal_point_next;
      pending_value      <= pending_value_next;
      pending_found      <= pending_found_next;
      stored_reading     <= stored_reading_next;
      sentence_length    <= sentence_length_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload register, loaded with the sentence's checksums as they stood
  always_ff @(posedge clk) begin
    if (emit) begin
      status            <= emit_status;
      reading           <= stored_reading_next;
      received_checksum <= hex_accum;
      computed_checksum <= running_xor;
    end
  end

  // ---------------------------------------------------------------- checks
  // a terminator while idle makes no result
  a_idle_term_silent: assert property (@(posedge clk) disable iff (rst)
    accept && is_term && phase == ckvsp_pkg::PH_IDLE |=> !out_valid)
    else $error("terminator in idle produced a result");

  // a shown result always carries the current stored reading
  a_reading_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reading == stored_reading)
    else $error("reading output differs from stored reading");

  // idle means a fully cleared sentence context
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == ckvsp_pkg::PH_IDLE |-> sentence_length == '0 && running_xor == '0
                                    && !pending_found)
    else $error("idle phase with stale sentence state");

  // a matching sentence with a pending pair updates the reading
  a_update: assert property (@(posedge clk) disable iff (rst)
    accept && is_term && phase == ckvsp_pkg::PH_HEX && hex_digits_seen == 2'd2 &&
    hex_accum == running_xor && pending_found
    |=> out_valid && status == ckvsp_pkg::ST_UPDATED && reading == $past(pending_value))
    else $error("valid sentence did not update reading");

endmodule

`default_nettype wire

// File: test/tb_checked_key_value_sentence_parser_core.sv
// Self-checking testbench for checked_key_value_sentence_parser_core.
// Streams framed key/value sentences and noise, predicts every result in place.
// Depends on ckvsp_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_checked_key_value_sentence_parser_core;

  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int HOLD_CYCLES    = 400;   // long output stall
  localparam int RANDOM_BYTES   = 400;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 8;     // margin after the last report is out
  localparam int KEY_WRITE_GAP  = 12;    // sentences between key changes

  // one sentence report as it leaves the core
  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] value;
    logic [7:0]  rx_sum;
    logic [7:0]  calc_sum;
  } sentence_result_t;

  // how the checksum field of a generated sentence is built
  typedef enum {
    CS_UPPER, CS_LOWER, CS_WRONG, CS_ONE_DIGIT, CS_THREE_DIGITS, CS_NOT_HEX, CS_MISSING
  } cs_style_t;

  // output ready patterns
  typedef enum {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [15:0] reading;
  logic [7:0]  received_checksum;
  logic [7:0]  computed_checksum;

  always #2 clk = ~clk;

  checked_key_value_sentence_parser_core dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .reading           (reading),
    .received_checksum (received_checksum),
    .computed_checksum (computed_checksum)
  );

  // ---------------------------------------------------------------------------
  // Parser shadow state. Updated once per accepted byte, in the order the core
  // accepts them, so every sentence report is known before the core emits it.
  // ---------------------------------------------------------------------------
  logic [7:0]  key_cfg;        // current match key
  logic [2:0]  phase;
  logic [7:0]  xor_sum;        // running XOR of body bytes
  logic [7:0]  hex_acc;        // checksum digits seen after '*'
  logic [1:0]  hex_cnt;
  logic        want_value;     // 0: next token is a key, 1: a value
  logic [7:0]  key_acc;
  logic [15:0] val_acc;
  logic        skip_rest;      // token number ended by a non-digit
  logic [15:0] held_value;     // last value paired with the match key
  logic        held_found;
  logic [15:0] saved_reading;  // survives sentences, cleared only by reset
  logic [7:0]  byte_count;     // sentence length so far, start byte included

  sentence_result_t reports_due[$];
  logic [7:0]       sentence_buf[$];  // bytes of the sentence being built

  // bookkeeping
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned sentences_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned key_writes = 0;
  int unsigned long_stalls = 0;
  int unsigned status_hits[4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  // sender / receiver pacing
  int unsigned burst_left = 0;
  bit          sender_gappy = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  rx_style_t   rx_mode = RX_ALWAYS;
  int unsigned rx_mode_left = 0;
  logic [1:0]  rx_phase = '0;

  function automatic void restart_sentence();
    phase      = ckvsp_pkg::PH_IDLE;
    xor_sum    = '0;
    hex_acc    = '0;
    hex_cnt    = '0;
    want_value = 1'b0;
    key_acc    = '0;
    val_acc    = '0;
    skip_rest  = 1'b0;
    held_value = '0;
    held_found = 1'b0;
    byte_count = '0;
  endfunction

  // A separator or '*' closes a token only if one is open; empty tokens vanish.
  function automatic void end_token();
    if (phase != ckvsp_pkg::PH_TOKEN) return;
    if (!want_value) begin
      want_value = 1'b1;
    end else begin
      if (key_acc == key_cfg) begin
        held_value = val_acc;
        held_found = 1'b1;
      end
      want_value = 1'b0;
    end
    key_acc   = '0;
    val_acc   = '0;
    skip_rest = 1'b0;
    phase     = ckvsp_pkg::PH_GAP;
  endfunction

  function automatic void take_body_char(input logic [7:0] c);
    logic [31:0] wide;
    phase = ckvsp_pkg::PH_TOKEN;
    if (skip_rest) return;
    if (c < ckvsp_pkg::CH_ZERO || c > ckvsp_pkg::CH_ZERO + 8'd9) begin
      skip_rest = 1'b1;  // fraction, sign or letters: rest of token ignored
      return;
    end
    if (!want_value) begin
      key_acc = key_acc * 8'd10 + (c - ckvsp_pkg::CH_ZERO);  // keeps low 8 bits
    end else begin
      wide    = 32'(val_acc) * 32'd10 + 32'(c - ckvsp_pkg::CH_ZERO);
      val_acc = (wide > 32'd65535) ? 16'hFFFF : wide[15:0];
    end
  endfunction

  // Advance the shadow parser by one accepted byte; queue a report on CR/LF.
  function automatic void track_sentence_byte(input logic [7:0] c);
    sentence_result_t r;
    logic             hex_ok;
    logic [7:0]       hex_val;
    if (c == ckvsp_pkg::CH_CR || c == ckvsp_pkg::CH_LF) begin
      if (phase == ckvsp_pkg::PH_IDLE) return;  // stray terminator between sentences
      if (phase != ckvsp_pkg::PH_HEX || hex_cnt != 2'd2) begin
        r.code = ckvsp_pkg::ST_MALFORMED;
      end else if (hex_acc != xor_sum) begin
        r.code = ckvsp_pkg::ST_MISMATCH;
      end else if (held_found) begin
        saved_reading = held_value;
        r.code = ckvsp_pkg::ST_UPDATED;
      end else begin
        r.code = ckvsp_pkg::ST_ABSENT;
      end
      r.value    = saved_reading;
      r.rx_sum   = hex_acc;
      r.calc_sum = xor_sum;
      reports_due.push_back(r);
      restart_sentence();
      return;
    end
    if (phase == ckvsp_pkg::PH_IDLE) begin
      phase      = ckvsp_pkg::PH_GAP;  // start byte, not part of the checksum
      byte_count = 8'd1;
      return;
    end
    if (phase == ckvsp_pkg::PH_DRAIN) return;
    if (byte_count >= ckvsp_pkg::MAX_SENTENCE) begin
      phase = ckvsp_pkg::PH_DRAIN;  // overlength
      return;
    end
    byte_count = byte_count + 8'd1;

    if (phase == ckvsp_pkg::PH_HEX) begin
      hex_ok  = 1'b1;
      hex_val = '0;
      if (c >= ckvsp_pkg::CH_ZERO && c <= ckvsp_pkg::CH_ZERO + 8'd9)
        hex_val = c - ckvsp_pkg::CH_ZERO;
      else if (c >= ckvsp_pkg::CH_UC_A && c <= ckvsp_pkg::CH_UC_A + 8'd5)
        hex_val = c - ckvsp_pkg::CH_UC_A + 8'd10;
      else if (c >= ckvsp_pkg::CH_LC_A && c <= ckvsp_pkg::CH_LC_A + 8'd5)
        hex_val = c - ckvsp_pkg::CH_LC_A + 8'd10;
      else
        hex_ok  = 1'b0;
      if (!hex_ok || hex_cnt >= 2'd2) begin
        phase = ckvsp_pkg::PH_DRAIN;
      end else begin
        hex_acc = {hex_acc[3:0], hex_val[3:0]};
        hex_cnt = hex_cnt + 2'd1;
      end
      return;
    end

    if (c == ckvsp_pkg::CH_STAR) begin
      end_token();  // an open key without value is dropped here
      phase   = ckvsp_pkg::PH_HEX;
      hex_acc = '0;
      hex_cnt = '0;
      return;
    end

    xor_sum = xor_sum ^ c;
    if (c == ckvsp_pkg::CH_COMMA || c == ckvsp_pkg::CH_COLON) end_token();
    else take_body_char(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Sentence construction
  // ---------------------------------------------------------------------------
  function automatic void put_char(input logic [7:0] c);
    sentence_buf.push_back(c);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) sentence_buf.push_back(s[i]);
  endfunction

  // XOR of everything after the start byte
  function automatic logic [7:0] body_xor();
    logic [7:0] x;
    x = '0;
    for (int i = 1; i < sentence_buf.size(); i++) x = x ^ sentence_buf[i];
    return x;
  endfunction

  // any byte that neither ends the sentence nor opens the checksum
  function automatic logic [7:0] pick_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ckvsp_pkg::CH_CR || b == ckvsp_pkg::CH_LF || b == ckvsp_pkg::CH_STAR);
    return b;
  endfunction

  // '$' + body + '*' + checksum (optionally corrupted) + terminator
  function automatic void put_framed(input string body, input logic [7:0] flip,
                                     input bit lower, input string term);
    sentence_buf.delete();
    put_char("$");
    put_text(body);
    if (lower) put_text($sformatf("*%02x", body_xor() ^ flip));
    else       put_text($sformatf("*%02X", body_xor() ^ flip));
    put_text(term);
  endfunction

  function automatic void put_key_text();
    case ($urandom_range(0, 4))
      0, 1:    put_text($sformatf("%0d", key_cfg));
      2:       put_text($sformatf("%0d", int'(key_cfg) + 256));  // wraps onto the key
      3:       put_text($sformatf("%0d", $urandom_range(0, 999)));
      default: put_text($sformatf("%0d.%0d", key_cfg, $urandom_range(0, 9)));
    endcase
  endfunction

  function automatic void put_value_text();
    case ($urandom_range(0, 7))
      0:       put_text($sformatf("%0d", $urandom_range(0, 999)));
      1:       put_text($sformatf("%0d", $urandom_range(0, 65535)));
      2:       put_text($sformatf("%0d", $urandom_range(65535, 999999)));  // saturates
      3:       put_text($sformatf("%0d.%0d", $urandom_range(0, 70000), $urandom_range(0, 999)));
      4:       put_text($sformatf("-%0d", $urandom_range(0, 500)));
      5:       put_text($sformatf("x%0d", $urandom_range(0, 500)));
      6:       put_text("99999999999");
      default: ;  // empty value token
    endcase
  endfunction

  function automatic cs_style_t pick_cs_style();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 11) return CS_UPPER;
    if (r < 13) return CS_LOWER;
    case (r)
      13, 14:  return CS_WRONG;
      15:      return CS_ONE_DIGIT;
      16:      return CS_THREE_DIGITS;
      17:      return CS_NOT_HEX;
      default: return CS_MISSING;
    endcase
  endfunction

  // Mostly well-formed sentences with random content, keys biased to the match key.
  function automatic void make_sentence();
    int unsigned n_tok;
    logic [7:0]  cs;
    case ($urandom_range(0, 3))
      0, 1:    begin sentence_buf.delete(); put_char("$"); end
      2:       begin sentence_buf.delete(); put_char("!"); end
      default: begin sentence_buf.delete(); put_char(pick_body_byte()); end
    endcase
    n_tok = $urandom_range(0, 6);
    for (int t = 0; t < n_tok; t++) begin
      if (t != 0 || $urandom_range(0, 3) == 0)
        put_char(($urandom_range(0, 1) != 0) ? ckvsp_pkg::CH_COMMA : ckvsp_pkg::CH_COLON);
      if ($urandom_range(0, 7) == 0) put_char(ckvsp_pkg::CH_COMMA);  // empty token
      if (t % 2 == 0) put_key_text();
      else            put_value_text();
      if ($urandom_range(0, 11) == 0) put_char(pick_body_byte());
    end
    cs = body_xor();
    case (pick_cs_style())
      CS_UPPER:        put_text($sformatf("*%02X", cs));
      CS_LOWER:        put_text($sformatf("*%02x", cs));
      CS_WRONG:        put_text($sformatf("*%02X", cs ^ 8'($urandom_range(1, 255))));
      CS_ONE_DIGIT:    put_text($sformatf("*%01X", cs[3:0]));
      CS_THREE_DIGITS: put_text($sformatf("*%02X%01x", cs, $urandom_range(0, 15)));
      CS_NOT_HEX:      put_text($sformatf("*%01XZ", cs[7:4]));
      default:         ;  // terminator before '*'
    endcase
    case ($urandom_range(0, 2))
      0:       put_char(ckvsp_pkg::CH_CR);
      1:       put_char(ckvsp_pkg::CH_LF);
      default: begin put_char(ckvsp_pkg::CH_CR); put_char(ckvsp_pkg::CH_LF); end
    endcase
  endfunction

  // raw bytes of any value, closed by LF so the next sentence starts clean
  function automatic void make_noise();
    sentence_buf.delete();
    repeat ($urandom_range(1, 12)) put_char(8'($urandom_range(0, 255)));
    put_char(ckvsp_pkg::CH_LF);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // One byte transaction. Bursts of random length, random gaps between them.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gappy ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    track_sentence_byte(b);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (sentence_buf[i]) send_byte(sentence_buf[i]);
    sentences_sent++;
  endtask

  // stop offering bytes and wait until every report has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_match_key(input logic [7:0] k);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    key_cfg = k;
    key_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: changes ready at the falling edge. A requested long hold overrides
  // the current pattern and is counted down here.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
      long_stalls++;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_style_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 128);
    end
    rx_mode_left--;
    rx_phase = rx_phase + 2'd1;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_ready <= (rx_phase != 2'b11);
        default:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every report transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input sentence_result_t want,
                                 input sentence_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"%0t: %0s: expected st=%0d rd=%0d rx=%02h calc=%02h,",
                " got st=%0d rd=%0d rx=%02h calc=%02h"},
               $realtime, what, want.code, want.value, want.rx_sum, want.calc_sum,
               got.code, got.value, got.rx_sum, got.calc_sum);
  endtask

  always @(posedge clk) begin : check_reports
    sentence_result_t got;
    sentence_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = '{status, reading, received_checksum, computed_checksum};
      reports_seen++;
      status_hits[got.code]++;
      if (reports_due.size() == 0) begin
        report_mismatch("report with no sentence pending", '0, got);
      end else begin
        want = reports_due.pop_front();
        if (got.code !== want.code || got.value !== want.value ||
            got.rx_sum !== want.rx_sum || got.calc_sum !== want.calc_sum)
          report_mismatch("report mismatch", want, got);
      end
    end
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d reports outstanding",
                 quiet_cycles, reports_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset key 0: stray terminator, empty tokens, fraction, lowercase digits,
  // mismatch, bad hex, early terminator, key left open at '*'.
  task automatic test_directed_sentences();
    sentence_buf.delete();
    put_char(ckvsp_pkg::CH_LF);
    send_buffer();
    put_framed(",0::9.7", 8'h00, 1'b1, "\r\n");  // reading 9, trailing LF ignored
    send_buffer();
    put_framed("0,70000", 8'h5A, 1'b0, "\n");    // checksum off, reading stays
    send_buffer();
    sentence_buf.delete();
    put_text("$1*G\n");
    send_buffer();
    sentence_buf.delete();
    put_text("$3,4\r");
    send_buffer();
    put_framed("5", 8'h00, 1'b0, "\n");          // key without value
    send_buffer();
  endtask

  // Key register extremes and key wrap at 8 bits.
  task automatic test_key_register();
    write_match_key(8'hFF);
    put_framed("255:65536", 8'h00, 1'b0, "\r");  // saturates
    send_buffer();
    put_framed("511,1234", 8'h00, 1'b0, "\n");   // 511 wraps to 255
    send_buffer();
    write_match_key(8'h00);
    put_framed("256,12ab,0,3", 8'h00, 1'b1, "\n");  // last match wins
    send_buffer();
    write_match_key(8'($urandom_range(1, 254)));
  endtask

  // Sentences of exactly the maximum length and one byte over.
  task automatic test_length_limit();
    for (int total = ckvsp_pkg::MAX_SENTENCE; total <= ckvsp_pkg::MAX_SENTENCE + 1;
         total++) begin
      sentence_buf.delete();
      put_char("$");
      put_text($sformatf("%0d:%0d", key_cfg, $urandom_range(0, 65535)));
      while (sentence_buf.size() < total - 3) put_char(ckvsp_pkg::CH_COMMA);
      put_text($sformatf("*%02X\n", body_xor()));
      send_buffer();
    end
  endtask

  // Long output stall fills the core and holds the input off; then the sender
  // pauses until everything is out before resuming.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (6) begin
      make_sentence();
      send_buffer();
    end
    drain_results();
    repeat (4) begin
      make_sentence();
      send_buffer();
    end
  endtask

  // Mostly well-formed random sentences, some noise, key changes now and then.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned first_byte;
    int unsigned since_write;
    first_byte  = bytes_sent;
    since_write = 0;
    while (bytes_sent - first_byte < n_bytes) begin
      if ($urandom_range(0, 99) < 12) make_noise();
      else                            make_sentence();
      send_buffer();
      if ($urandom_range(0, 7) == 0) sender_gappy = ~sender_gappy;
      if (++since_write == KEY_WRITE_GAP) begin
        since_write = 0;
        case ($urandom_range(0, 3))
          0:       write_match_key(8'h00);
          1:       write_match_key(8'hFF);
          default: write_match_key(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;
    key_cfg       = '0;
    saved_reading = '0;
    restart_sentence();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_sentences();
    test_key_register();
    test_length_limit();
    test_output_backpressure();
    test_random_traffic(RANDOM_BYTES);

    drain_results();
    $display("sent %0d bytes in %0d sentences, %0d key writes, %0d long output stalls",
             bytes_sent, sentences_sent, key_writes, long_stalls);
    $display("checked %0d reports: %0d updated, %0d mismatch, %0d absent, %0d malformed",
             reports_seen, status_hits[ckvsp_pkg::ST_UPDATED],
             status_hits[ckvsp_pkg::ST_MISMATCH], status_hits[ckvsp_pkg::ST_ABSENT],
             status_hits[ckvsp_pkg::ST_MALFORMED]);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ckvsp_pkg.sv
rtl/core/checked_key_value_sentence_parser_core.sv
test/tb_checked_key_value_sentence_parser_core.sv
